>>> rtl/asc_pkg.sv
// shared constants and action codes for the adaptive sample skip controller
package asc_pkg;

    localparam int SKIP_W            = 14;
    localparam int CFG_W             = 24;
    localparam int PROD_W            = SKIP_W + CFG_W;
    localparam int ACT_W             = 2;
    localparam int OUT_DATA_W        = 16;
    localparam int MUL_CNT_W         = $clog2(SKIP_W);
    localparam int DIV_CNT_W         = $clog2(PROD_W);

    localparam int DEF_MAX_SKIPS     = 10000;
    localparam int DEF_TIME_BITS     = 48;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = CFG_W'(10000);

    localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STOP   = 2'd2;

endpackage

>>> rtl/asc_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
module asc_mul
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [asc_pkg::SKIP_W-1:0]    mplier,
    input  logic [asc_pkg::CFG_W-1:0]     mcand,
    output logic                          done,
    output logic [asc_pkg::PROD_W-1:0]    product
);
    import asc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0]    acc_reg, acc_next;
    logic [PROD_W-1:0]    mcand_reg, mcand_next;
    logic [SKIP_W-1:0]    mplier_reg, mplier_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = MUL_CNT_W'(SKIP_W - 1);
            acc_next    = '0;
            mcand_next  = PROD_W'(mcand);
            mplier_next = mplier;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[SKIP_W-1:1]};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> rtl/asc_div.sv
// restoring divider, one quotient bit per cycle, saturating clamped quotient
module asc_div #(
    parameter int TIME_BITS = asc_pkg::DEF_TIME_BITS,
    parameter int MAX_SKIPS = asc_pkg::DEF_MAX_SKIPS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [asc_pkg::PROD_W-1:0]    dividend,
    input  logic [TIME_BITS-1:0]          divisor,
    output logic                          done,
    output logic [asc_pkg::SKIP_W-1:0]    quotient
);
    import asc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0]    dvd_reg, dvd_next;
    logic [TIME_BITS-1:0] dvs_reg, dvs_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [SKIP_W-1:0]    q_reg, q_next;
    logic                 ovf_reg, ovf_next;
    logic [TIME_BITS:0]   trial;
    logic [TIME_BITS+1:0] sub;

    assign trial = {rem_reg, dvd_reg[PROD_W-1]};
    assign sub   = {1'b0, trial} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(PROD_W - 1);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[PROD_W-2:0], 1'b0};
            ovf_next = ovf_reg | q_reg[SKIP_W-1];
            if (!sub[TIME_BITS+1])
            begin
                rem_next = sub[TIME_BITS-1:0];
                q_next   = {q_reg[SKIP_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[TIME_BITS-1:0];
                q_next   = {q_reg[SKIP_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    // clamp to 1..max skips
    always_comb
    begin
        priority if (ovf_reg || (q_reg > SKIP_W'(MAX_SKIPS)))
        begin
            quotient = SKIP_W'(MAX_SKIPS);
        end
        else if (q_reg == '0)
        begin
            quotient = SKIP_W'(1);
        end
        else
        begin
            quotient = q_reg;
        end
    end

    assign done = done_reg;

endmodule

>>> rtl/adaptive_sample_skip_controller_core.sv
// adaptive sample skip controller top level: session state, retune sequencing, item ports
//
// channel   direction  contents
// s_*       in         tuser: action[1:0]; tdata: now_us[TIME_BITS-1:0], zero padded
// m_*       out        tdata: take_sample[0], skips_in_use[14:1], zero padded to 16
// cfg_*     in         data: desired_interval_us[23:0]
//
// an item that does not retune passes its result through the staging register and
// then the output register to m_tvalid; the next item waits while staging is full
// a retuning item runs 14 multiplier steps and then 38 divider steps, each unit loading
// its operands first, and then stores the new period; its result then passes through
// the staging and output registers, and no item is taken until the retune is over
// one finished result may wait in a staging register while m_tready is low; s_tready drops
// only while a retune runs or the staging register is full
// rst_n resets all session state (skip periods to 1), sets the interval register to 10000
module adaptive_sample_skip_controller_core #(
    parameter int TIME_BITS = asc_pkg::DEF_TIME_BITS,
    parameter int MAX_SKIPS = asc_pkg::DEF_MAX_SKIPS,
    localparam int IN_DATA_W = ((TIME_BITS + 7) / 8) * 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [IN_DATA_W-1:0]              s_tdata,  // now_us
    input  logic [asc_pkg::ACT_W-1:0]         s_tuser,  // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [asc_pkg::OUT_DATA_W-1:0]    m_tdata,  // take_sample, skips_in_use
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [asc_pkg::CFG_W-1:0]         cfg_data  // desired_interval_us
);
    import asc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CFG_W-1:0]      interval_reg, interval_next;
    logic [SKIP_W-1:0]     skip_count_reg, skip_count_next;
    logic [SKIP_W-1:0]     spp_reg, spp_next;
    logic [SKIP_W-1:0]     prev_skips_reg, prev_skips_next;
    logic [TIME_BITS-1:0]  last_time_reg, last_time_next;
    logic                  last_valid_reg, last_valid_next;
    logic                  active_reg, active_next;
    logic [TIME_BITS-1:0]  elapsed_reg, elapsed_next;
    logic                  res_valid_reg, res_valid_next;
    logic                  res_take_reg, res_take_next;
    logic [SKIP_W-1:0]     res_skips_reg, res_skips_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                  accept;
    logic [TIME_BITS-1:0]  now;
    logic [SKIP_W-1:0]     count_inc;
    logic [TIME_BITS:0]    diff;
    logic                  now_later;
    logic                  mul_start;
    logic                  mul_done;
    logic [PROD_W-1:0]     product;
    logic                  div_done;
    logic [SKIP_W-1:0]     new_skips;

    assign s_tready  = (state_reg == ST_IDLE) && !res_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign now       = s_tdata[TIME_BITS-1:0];
    assign count_inc = skip_count_reg + 1'b1;
    assign diff      = {1'b0, now} - {1'b0, last_time_reg};
    assign now_later = !diff[TIME_BITS] && (diff[TIME_BITS-1:0] != '0);
    assign cfg_ready = 1'b1;

    asc_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mplier  (prev_skips_reg),
        .mcand   (interval_reg),
        .done    (mul_done),
        .product (product)
    );

    asc_div #(
        .TIME_BITS (TIME_BITS),
        .MAX_SKIPS (MAX_SKIPS)
    ) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_done),
        .dividend (product),
        .divisor  (elapsed_reg),
        .done     (div_done),
        .quotient (new_skips)
    );

    always_comb
    begin
        state_next      = state_reg;
        interval_next   = interval_reg;
        skip_count_next = skip_count_reg;
        spp_next        = spp_reg;
        prev_skips_next = prev_skips_reg;
        last_time_next  = last_time_reg;
        last_valid_next = last_valid_reg;
        active_next     = active_reg;
        elapsed_next    = elapsed_reg;
        res_valid_next  = res_valid_reg;
        res_take_next   = res_take_reg;
        res_skips_next  = res_skips_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        mul_start       = 1'b0;

        if (cfg_valid)
        begin
            interval_next = cfg_data;
        end

        // staging register to output register
        if (res_valid_reg && (!out_valid_reg || m_tready))
        begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_DATA_W'({res_skips_reg, res_take_reg});
            res_valid_next = 1'b0;
        end
        else if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_valid_next = 1'b1;
                    res_take_next  = 1'b0;
                    res_skips_next = spp_reg;
                    unique case (s_tuser)
                        ACT_SAMPLE:
                        begin
                            if (count_inc < spp_reg)
                            begin
                                skip_count_next = count_inc;
                            end
                            else
                            begin
                                skip_count_next = '0;
                                if (active_reg)
                                begin
                                    last_time_next  = now;
                                    last_valid_next = 1'b1;
                                    res_take_next   = 1'b1;
                                    if (last_valid_reg && now_later)
                                    begin
                                        elapsed_next   = diff[TIME_BITS-1:0];
                                        mul_start      = 1'b1;
                                        res_valid_next = 1'b0;
                                        state_next     = ST_MUL;
                                    end
                                end
                            end
                        end
                        ACT_START:
                        begin
                            skip_count_next = '0;
                            spp_next        = SKIP_W'(1);
                            prev_skips_next = SKIP_W'(1);
                            last_time_next  = '0;
                            last_valid_next = 1'b0;
                            active_next     = 1'b1;
                            res_skips_next  = SKIP_W'(1);
                        end
                        ACT_STOP:
                        begin
                            active_next     = 1'b0;
                            skip_count_next = '0;
                            spp_next        = SKIP_W'(1);
                            res_skips_next  = SKIP_W'(1);
                        end
                        default:
                        begin
                            res_skips_next = spp_reg;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    prev_skips_next = spp_reg;
                    spp_next        = new_skips;
                    res_valid_next  = 1'b1;
                    res_take_next   = 1'b1;
                    res_skips_next  = new_skips;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            interval_reg   <= INTERVAL_RESET;
            skip_count_reg <= '0;
            spp_reg        <= SKIP_W'(1);
            prev_skips_reg <= SKIP_W'(1);
            last_time_reg  <= '0;
            last_valid_reg <= 1'b0;
            active_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            interval_reg   <= interval_next;
            skip_count_reg <= skip_count_next;
            spp_reg        <= spp_next;
            prev_skips_reg <= prev_skips_next;
            last_time_reg  <= last_time_next;
            last_valid_reg <= last_valid_next;
            active_reg     <= active_next;
            res_valid_reg  <= res_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg   <= elapsed_next;
        res_take_reg  <= res_take_next;
        res_skips_reg <= res_skips_next;
        out_data_reg  <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
